>>> hdl/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg
// Shared types and constants of the elevator dispatch controller.
// ----------------------------------------------------------------------------
package edc_pkg;

	localparam int FLOOR_W = 5;
	localparam int WGT_W   = 8;
	localparam int LOAD_W  = 12;
	localparam int CAP_W   = 5;
	localparam int CFG_W   = 12;
	localparam int CIDX_W  = 2;

	localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

	// result status codes
	localparam logic [1:0] ST_STORED  = 2'd0;
	localparam logic [1:0] ST_DROPPED = 2'd1;
	localparam logic [1:0] ST_ARRIVED = 2'd2;

	// request function codes
	localparam logic FN_REQUEST = 1'b0;
	localparam logic FN_ARRIVAL = 1'b1;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_LIMIT    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_MARGIN   = 2'd2;

	localparam logic [CAP_W-1:0]  CAPACITY_RST = 5'd10;
	localparam logic [LOAD_W-1:0] LIMIT_RST    = 12'd600;
	localparam logic [WGT_W-1:0]  MARGIN_RST   = 8'd80;
	localparam logic [FLOOR_W-1:0] FLOOR_RST   = 5'd1;

	typedef struct packed {
		logic               func;
		logic [FLOOR_W-1:0] request_start;
		logic [FLOOR_W-1:0] request_end;
		logic [WGT_W-1:0]   request_weight;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FLOOR_W-1:0] current_floor;
		logic [FLOOR_W-1:0] target_floor;
		logic [CAP_W-1:0]   riders;
		logic [LOAD_W-1:0]  car_weight;
		logic               moving;
	} out_item_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic [FLOOR_W-1:0] from_floor;
		logic [FLOOR_W-1:0] to_floor;
		logic [WGT_W-1:0]   weight;
	} slot_t;

endpackage

>>> hdl/edc_in_if.sv
// ----------------------------------------------------------------------------
// edc_in_if
// Request channel: valid/ready handshake with one input item as payload.
// ----------------------------------------------------------------------------
interface edc_in_if import edc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/edc_out_if.sv
// ----------------------------------------------------------------------------
// edc_out_if
// Result channel: valid/ready handshake with one result item as payload.
// ----------------------------------------------------------------------------
interface edc_out_if import edc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/elevator_dispatch_controller.sv
// ----------------------------------------------------------------------------
// elevator_dispatch_controller
// Single-car dispatch over a passenger table kept in arrival order.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+------------------------------------------
//   req     | in  | valid/ready   | func, request_start/end, request_weight
//   res     | out | valid/ready   | status, floors, riders, car_weight, moving
//   cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// Sequencing: a stored request on a busy car or a dropped one goes straight
// to the result; a request on an idle car adds a target pass over the table
// entries. An arrival runs one alight sweep over every slot, then a board
// and a target pass in arrival order, one slot-memory read per cycle. No
// clearing pass after reset; valid bits gate every read. req is taken only
// while the sequencer is idle; a result waiting on res does not hold off the
// next request.
// ----------------------------------------------------------------------------
module elevator_dispatch_controller import edc_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int FLOORS      = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	edc_in_if.sink            req,
	edc_out_if.source         res,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = ($clog2(FLOORS + 1) > FLOOR_W) ? $clog2(FLOORS + 1) : FLOOR_W;

	localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
	localparam logic [RW-1:0] FLOORS_C = RW'(FLOORS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ALIGHT = 3'd1;
	localparam logic [2:0] S_BOARD  = 3'd2;
	localparam logic [2:0] S_PICK   = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	// configuration
	logic [CAP_W-1:0]  capacity_q;
	logic [LOAD_W-1:0] limit_q;
	logic [WGT_W-1:0]  margin_q;

	// control and car state
	logic [2:0]           state_q;
	logic [1:0]           status_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        n_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] inside_q;
	logic [FLOOR_W-1:0]   cur_q;
	logic [FLOOR_W-1:0]   next_q;
	logic [CAP_W-1:0]     riders_q;
	logic [LOAD_W-1:0]    load_q;
	logic                 busy_q;
	logic [RW-1:0]        best_q;
	logic                 best_v_q;
	logic                 res_valid_q;
	logic                 v_s1;

	// payload registers
	logic [IW-1:0]        age_q [TABLE_DEPTH];
	logic [IW-1:0]        slot_s1;
	out_item_t            res_data_q;
	slot_t                slot_mem [TABLE_DEPTH];
	slot_t                rd_q;

	// combinational
	logic [IW-1:0]        free_idx;
	logic [IW-1:0]        rank_idx;
	logic [IW-1:0]        rd_addr;
	logic [CW-1:0]        scan_limit;
	logic                 scanning;
	logic                 issue;
	logic                 req_fire;
	logic                 store;
	logic                 res_load;
	logic                 alight_hit;
	logic                 board_hit;
	logic                 car_full;
	logic                 cand_v;
	logic [FLOOR_W-1:0]   cand_floor;
	logic [FLOOR_W-1:0]   cand_dist;
	logic [RW-1:0]        cand_rank;
	logic [LOAD_W:0]      board_sum;
	logic [LOAD_W:0]      load_add;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign store     = req_fire && (req.data.func == FN_REQUEST) && (n_q != DEPTH_C);
	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;
	assign res_load  = (state_q == S_DONE) && (!res_valid_q || res.ready);

	// first free slot
	always_comb begin
		free_idx = '0;
		for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
			if (!valid_q[k]) free_idx = IW'(k);
		end
	end

	// slot holding arrival rank cnt_q
	always_comb begin
		rank_idx = '0;
		for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
			if (valid_q[k] && age_q[k] == cnt_q[IW-1:0]) rank_idx = IW'(k);
		end
	end

	assign scanning   = (state_q == S_ALIGHT) || (state_q == S_BOARD) || (state_q == S_PICK);
	assign scan_limit = (state_q == S_ALIGHT) ? DEPTH_C : n_q;
	assign issue      = scanning && (cnt_q < scan_limit);
	assign rd_addr    = (state_q == S_ALIGHT) ? cnt_q[IW-1:0] : rank_idx;

	// evaluation of the entry read last cycle
	assign alight_hit = v_s1 && (state_q == S_ALIGHT) && valid_q[slot_s1] &&
	                    inside_q[slot_s1] && (rd_q.to_floor == cur_q);

	assign board_sum  = {1'b0, load_q} + {{(LOAD_W + 1 - WGT_W){1'b0}}, margin_q};
	assign load_add   = {1'b0, load_q} + {{(LOAD_W + 1 - WGT_W){1'b0}}, rd_q.weight};
	assign board_hit  = v_s1 && (state_q == S_BOARD) && !inside_q[slot_s1] &&
	                    (rd_q.from_floor == cur_q) && (riders_q < capacity_q) &&
	                    (board_sum < {1'b0, limit_q});

	assign car_full   = (riders_q >= capacity_q);
	always_comb begin
		cand_v     = 1'b0;
		cand_floor = rd_q.from_floor;
		if (inside_q[slot_s1]) begin
			cand_v     = 1'b1;
			cand_floor = rd_q.to_floor;
		end else if (!car_full) begin
			cand_v     = 1'b1;
		end
		cand_dist = (cand_floor >= cur_q) ? cand_floor - cur_q : cur_q - cand_floor;
		cand_rank = (cand_dist == '0) ? FLOORS_C : RW'(cand_dist);
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store) begin
			slot_mem[free_idx] <= '{from_floor: req.data.request_start,
			                        to_floor:   req.data.request_end,
			                        weight:     req.data.request_weight};
		end
		rd_q <= slot_mem[rd_addr];
	end

	// arrival ranks; a leaving entry closes the gap behind it
	always_ff @(posedge clk) begin
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (alight_hit && valid_q[k] && age_q[k] > age_q[slot_s1]) begin
				age_q[k] <= age_q[k] - 1'b1;
			end
		end
		if (store) age_q[free_idx] <= n_q[IW-1:0];
		if (issue) slot_s1 <= rd_addr;
		if (res_load) begin
			res_data_q <= '{status:        status_q,
			                current_floor: cur_q,
			                target_floor:  next_q,
			                riders:        riders_q,
			                car_weight:    load_q,
			                moving:        busy_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAPACITY_RST;
			limit_q     <= LIMIT_RST;
			margin_q    <= MARGIN_RST;
			state_q     <= S_IDLE;
			status_q    <= ST_STORED;
			cnt_q       <= '0;
			n_q         <= '0;
			valid_q     <= '0;
			inside_q    <= '0;
			cur_q       <= FLOOR_RST;
			next_q      <= FLOOR_RST;
			riders_q    <= '0;
			load_q      <= '0;
			busy_q      <= 1'b0;
			best_q      <= '0;
			best_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CAPACITY: capacity_q <= cfg_data[CAP_W-1:0];
					CFG_LIMIT:    limit_q    <= cfg_data[LOAD_W-1:0];
					CFG_MARGIN:   margin_q   <= cfg_data[WGT_W-1:0];
					default: ;
				endcase
			end

			if (res_valid_q && res.ready && !res_load) res_valid_q <= 1'b0;

			v_s1 <= issue;
			if (issue) cnt_q <= cnt_q + 1'b1;

			if (alight_hit) begin
				if (riders_q != '0) riders_q <= riders_q - 1'b1;
				load_q <= (load_q >= LOAD_W'(rd_q.weight)) ?
				          load_q - LOAD_W'(rd_q.weight) : '0;
				valid_q[slot_s1]  <= 1'b0;
				inside_q[slot_s1] <= 1'b0;
				n_q <= n_q - 1'b1;
			end

			if (board_hit) begin
				inside_q[slot_s1] <= 1'b1;
				riders_q <= riders_q + 1'b1;
				load_q   <= load_add[LOAD_W] ? LOAD_MAX : load_add[LOAD_W-1:0];
			end

			if (v_s1 && state_q == S_PICK && cand_v && (!best_v_q || cand_rank < best_q)) begin
				best_q   <= cand_rank;
				best_v_q <= 1'b1;
				next_q   <= cand_floor;
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.data.func == FN_ARRIVAL) begin
							status_q <= ST_ARRIVED;
							cur_q    <= next_q;
							cnt_q    <= '0;
							state_q  <= S_ALIGHT;
						end else if (n_q == DEPTH_C) begin
							status_q <= ST_DROPPED;
							state_q  <= S_DONE;
						end else begin
							status_q <= ST_STORED;
							valid_q[free_idx]  <= 1'b1;
							inside_q[free_idx] <= 1'b0;
							n_q <= n_q + 1'b1;
							if (!busy_q) begin
								next_q   <= cur_q;
								best_v_q <= 1'b0;
								cnt_q    <= '0;
								state_q  <= S_PICK;
							end else begin
								state_q  <= S_DONE;
							end
						end
					end
				end
				S_ALIGHT: begin
					if (!issue && !v_s1) begin
						cnt_q   <= '0;
						state_q <= S_BOARD;
					end
				end
				S_BOARD: begin
					if (!issue && !v_s1) begin
						next_q   <= cur_q;
						best_v_q <= 1'b0;
						cnt_q    <= '0;
						state_q  <= S_PICK;
					end
				end
				S_PICK: begin
					if (!issue && !v_s1) begin
						busy_q  <= (n_q != '0);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
